FILE: hw/rtl/trs_pkg.sv
// Shared widths, fixed-point constants and types of the transform matrix pipeline.
package trs_pkg;

    localparam int FW        = 32;            // width of every Q16.16 field
    localparam int N_IN      = 9;
    localparam int N_OUT     = 12;
    localparam int IN_W      = FW * N_IN;
    localparam int OUT_W     = FW * N_OUT;

    // Angle reduction: bias to a positive value, then eight compare-subtract steps.
    localparam int RED_W     = 33;
    localparam int RED_STEPS = 8;
    localparam logic [RED_W-1:0] DEG360_U   = 33'd23592960;
    localparam logic [RED_W:0]   ANGLE_BIAS = 34'd2170552320;   // 92 turns

    localparam int ZW = 26;
    localparam logic signed [ZW-1:0] DEG90_Z  = 26'sd5898240;
    localparam logic signed [ZW-1:0] DEG180_Z = 26'sd11796480;
    localparam logic signed [ZW-1:0] DEG360_Z = 26'sd23592960;

    localparam int CORDIC_ITERS = 17;
    localparam int XW           = 34;
    localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [XW-1:0] ONE_X       = 34'sd1073741824;

    localparam int ANGLE_LAT  = RED_STEPS + 2;
    localparam int CORDIC_LAT = CORDIC_ITERS + 1;
    localparam int FRONT_LAT  = ANGLE_LAT + CORDIC_LAT;

    typedef logic signed [FW-1:0] q16_t;
    typedef logic signed [FW-1:0] trig_t;     // Q2.30, within [-1, 1]
    typedef logic signed [ZW-1:0] zang_t;

    typedef struct packed {
        q16_t x;
        q16_t y;
        q16_t z;
    } vec3_t;

    function automatic int atan_q16(input int i);
        int r;
        case (i)
            0:       r = 2949120;
            1:       r = 1740967;
            2:       r = 919879;
            3:       r = 466945;
            4:       r = 234379;
            5:       r = 117304;
            6:       r = 58666;
            7:       r = 29335;
            8:       r = 14668;
            9:       r = 7334;
            10:      r = 3667;
            11:      r = 1833;
            12:      r = 917;
            13:      r = 458;
            14:      r = 229;
            15:      r = 115;
            16:      r = 57;
            default: r = 0;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/trs_transform_matrix.sv
// Top level of the translate-rotate-scale model matrix pipeline.
//
// Each input word carries a translation, three Euler angles in degrees and a per-axis
// scale, all signed Q16.16, and produces one output word with the top three rows of
// T*Rx*Ry*Rz*S. The bottom row is always 0 0 0 1 and is not sent. A new word is
// accepted every clock cycle while the pipeline advances, and each result passes
// through 10 stages of angle reduction (a bias add, eight compare-subtract steps of a
// full turn and a fold into [-90, 90] degrees), 18 stages of CORDIC (one iteration per
// stage plus a clamp and sign stage) and 5 stages of products, scaling and saturation.
// The three angles run through three copies of that front end side by side. The whole
// pipeline advances together whenever the output register is empty or being taken, so
// s_tready simply follows m_tready while a result waits and nothing is ever dropped or
// repeated. Rotation entries are rounded to nearest at every product, scaled entries
// saturate to the 32-bit range, and the translation column is copied unchanged.
module trs_transform_matrix (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // translation_x, translation_y, translation_z, angle_x_deg, angle_y_deg,
    // angle_z_deg, scale_x, scale_y, scale_z; 32 bits each, lowest first
    input  logic [trs_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // m00, m01, m02, m03, m10, m11, m12, m13, m20, m21, m22, m23; 32 bits each,
    // lowest first
    output logic [trs_pkg::OUT_W-1:0]  m_tdata
);
    import trs_pkg::*;

    logic  en;
    zang_t z_ang [0:2];
    logic  neg_ang [0:2];
    trig_t sin_ang [0:2];
    trig_t cos_ang [0:2];
    logic  vld_reg [0:FRONT_LAT-1];
    vec3_t scl_reg [0:FRONT_LAT-1];
    vec3_t tr_reg  [0:FRONT_LAT-1];
    vec3_t scl_in;
    vec3_t tr_in;

    // The output register is free or being emptied: every stage may move.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign tr_in.x  = s_tdata[0*FW +: FW];
    assign tr_in.y  = s_tdata[1*FW +: FW];
    assign tr_in.z  = s_tdata[2*FW +: FW];
    assign scl_in.x = s_tdata[6*FW +: FW];
    assign scl_in.y = s_tdata[7*FW +: FW];
    assign scl_in.z = s_tdata[8*FW +: FW];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        trs_angle_reduce u_reduce (
            .aclk    (aclk),
            .en      (en),
            .angle_i (s_tdata[(3+a)*FW +: FW]),
            .z_o     (z_ang[a]),
            .neg_o   (neg_ang[a])
        );

        trs_cordic u_cordic (
            .aclk  (aclk),
            .en    (en),
            .z_i   (z_ang[a]),
            .neg_i (neg_ang[a]),
            .sin_o (sin_ang[a]),
            .cos_o (cos_ang[a])
        );
    end

    // Valid bits and the pass-through fields keep step with the angle front end.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < FRONT_LAT; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < FRONT_LAT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            scl_reg[0] <= scl_in;
            tr_reg[0]  <= tr_in;
            for (int i = 1; i < FRONT_LAT; i++) begin
                scl_reg[i] <= scl_reg[i-1];
                tr_reg[i]  <= tr_reg[i-1];
            end
        end
    end

    trs_matrix u_matrix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .valid_i (vld_reg[FRONT_LAT-1]),
        .sa_i    (sin_ang[0]),
        .ca_i    (cos_ang[0]),
        .sb_i    (sin_ang[1]),
        .cb_i    (cos_ang[1]),
        .sc_i    (sin_ang[2]),
        .cc_i    (cos_ang[2]),
        .scale_i (scl_reg[FRONT_LAT-1]),
        .trans_i (tr_reg[FRONT_LAT-1]),
        .valid_o (m_tvalid),
        .data_o  (m_tdata)
    );

endmodule

FILE: hw/rtl/trs_angle_reduce.sv
// Angle reduction pipeline: wraps a Q16.16 angle into [-90, 90] degrees with a negate flag.
module trs_angle_reduce (
    input  logic          aclk,
    input  logic          en,
    input  trs_pkg::q16_t angle_i,
    output trs_pkg::zang_t z_o,
    output logic          neg_o
);
    import trs_pkg::*;

    logic [RED_W-1:0] u_reg [0:RED_STEPS];
    zang_t            z_reg;
    logic             neg_reg;
    zang_t            m_a;
    zang_t            m_b;
    logic             neg_b;

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg[0] <= RED_W'({{2{angle_i[FW-1]}}, angle_i} + ANGLE_BIAS);
        end
    end

    // One restoring step per stage, largest multiple of a full turn first.
    for (genvar k = 0; k < RED_STEPS; k++) begin : g_step
        localparam logic [RED_W-1:0] SUB = DEG360_U << (RED_STEPS - 1 - k);
        always_ff @(posedge aclk) begin
            if (en) begin
                u_reg[k+1] <= (u_reg[k] >= SUB) ? u_reg[k] - SUB : u_reg[k];
            end
        end
    end

    always_comb begin
        m_a = signed'({1'b0, u_reg[RED_STEPS][ZW-2:0]});
        if (m_a > DEG180_Z) begin
            m_a = m_a - DEG360_Z;
        end
        neg_b = 1'b0;
        m_b   = m_a;
        if (m_a > DEG90_Z) begin
            m_b   = m_a - DEG180_Z;
            neg_b = 1'b1;
        end else if (m_a < -DEG90_Z) begin
            m_b   = m_a + DEG180_Z;
            neg_b = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg   <= m_b;
            neg_reg <= neg_b;
        end
    end

    assign z_o   = z_reg;
    assign neg_o = neg_reg;

endmodule

FILE: hw/rtl/trs_cordic.sv
// Unrolled rotation-mode CORDIC, one iteration per stage, giving sine and cosine in Q2.30.
module trs_cordic (
    input  logic           aclk,
    input  logic           en,
    input  trs_pkg::zang_t z_i,
    input  logic           neg_i,
    output trs_pkg::trig_t sin_o,
    output trs_pkg::trig_t cos_o
);
    import trs_pkg::*;

    logic signed [XW-1:0] x_in  [0:CORDIC_ITERS-1];
    logic signed [XW-1:0] y_in  [0:CORDIC_ITERS-1];
    zang_t                z_in  [0:CORDIC_ITERS-1];
    logic                 n_in  [0:CORDIC_ITERS-1];
    logic signed [XW-1:0] x_reg [0:CORDIC_ITERS-1];
    logic signed [XW-1:0] y_reg [0:CORDIC_ITERS-1];
    zang_t                z_reg [0:CORDIC_ITERS-1];
    logic                 n_reg [0:CORDIC_ITERS-1];
    logic signed [XW-1:0] xc;
    logic signed [XW-1:0] yc;
    trig_t                sin_reg;
    trig_t                cos_reg;

    for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
        localparam zang_t ATAN = ZW'(atan_q16(i));
        if (i == 0) begin : g_first
            assign x_in[i] = CORDIC_GAIN;
            assign y_in[i] = '0;
            assign z_in[i] = z_i;
            assign n_in[i] = neg_i;
        end else begin : g_next
            assign x_in[i] = x_reg[i-1];
            assign y_in[i] = y_reg[i-1];
            assign z_in[i] = z_reg[i-1];
            assign n_in[i] = n_reg[i-1];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                if (z_in[i] >= 0) begin
                    x_reg[i] <= x_in[i] - (y_in[i] >>> i);
                    y_reg[i] <= y_in[i] + (x_in[i] >>> i);
                    z_reg[i] <= z_in[i] - ATAN;
                end else begin
                    x_reg[i] <= x_in[i] + (y_in[i] >>> i);
                    y_reg[i] <= y_in[i] - (x_in[i] >>> i);
                    z_reg[i] <= z_in[i] + ATAN;
                end
                n_reg[i] <= n_in[i];
            end
        end
    end

    always_comb begin
        xc = x_reg[CORDIC_ITERS-1];
        yc = y_reg[CORDIC_ITERS-1];
        if (xc > ONE_X) xc = ONE_X;
        if (xc < -ONE_X) xc = -ONE_X;
        if (yc > ONE_X) yc = ONE_X;
        if (yc < -ONE_X) yc = -ONE_X;
        if (n_reg[CORDIC_ITERS-1]) begin
            xc = -xc;
            yc = -yc;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= FW'(xc);
            sin_reg <= FW'(yc);
        end
    end

    assign sin_o = sin_reg;
    assign cos_o = cos_reg;

endmodule

FILE: hw/rtl/trs_matrix.sv
// Product pipeline: forms the rotation entries, applies the scale and saturates to Q16.16.
module trs_matrix (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        valid_i,
    input  trs_pkg::trig_t              sa_i,
    input  trs_pkg::trig_t              ca_i,
    input  trs_pkg::trig_t              sb_i,
    input  trs_pkg::trig_t              cb_i,
    input  trs_pkg::trig_t              sc_i,
    input  trs_pkg::trig_t              cc_i,
    input  trs_pkg::vec3_t              scale_i,
    input  trs_pkg::vec3_t              trans_i,
    output logic                        valid_o,
    output logic [trs_pkg::OUT_W-1:0]   data_o
);
    import trs_pkg::*;

    localparam int RW = FW + 1;
    localparam int PW = RW + FW;
    localparam int VW = PW - 30;

    function automatic trig_t mul_q30(input trig_t a, input trig_t b);
        logic signed [2*FW-1:0] p;
        p = (2*FW)'(a) * (2*FW)'(b) + 64'sd536870912;
        return FW'(p >>> 30);
    endfunction

    // Stage one: two-factor products.
    trig_t sasb1_reg, casb1_reg, cbcc1_reg, cbsc1_reg, casc1_reg;
    trig_t cacc1_reg, sacb1_reg, sasc1_reg, sacc1_reg, cacb1_reg;
    trig_t sb1_reg, sc1_reg, cc1_reg;
    vec3_t scl1_reg, tr1_reg;
    logic  v1_reg;
    // Stage two: three-factor products.
    trig_t sasbcc2_reg, sasbsc2_reg, casbcc2_reg, casbsc2_reg;
    trig_t cbcc2_reg, cbsc2_reg, casc2_reg, cacc2_reg, sacb2_reg;
    trig_t sasc2_reg, sacc2_reg, cacb2_reg, sb2_reg;
    vec3_t scl2_reg, tr2_reg;
    logic  v2_reg;
    // Stage three: rotation entries, row-major.
    logic signed [RW-1:0] r3_reg [0:8];
    vec3_t scl3_reg, tr3_reg;
    logic  v3_reg;
    // Stage four: scaled products.
    logic signed [PW-1:0] p4_reg [0:8];
    vec3_t tr4_reg;
    logic  v4_reg;
    // Stage five: output word.
    logic [OUT_W-1:0] data_reg;
    logic             v5_reg;
    q16_t             scl3 [0:2];
    q16_t             tr4 [0:2];
    q16_t             entry_sat [0:8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= valid_i;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sasb1_reg <= mul_q30(sa_i, sb_i);
            casb1_reg <= mul_q30(ca_i, sb_i);
            cbcc1_reg <= mul_q30(cb_i, cc_i);
            cbsc1_reg <= mul_q30(cb_i, sc_i);
            casc1_reg <= mul_q30(ca_i, sc_i);
            cacc1_reg <= mul_q30(ca_i, cc_i);
            sacb1_reg <= mul_q30(sa_i, cb_i);
            sasc1_reg <= mul_q30(sa_i, sc_i);
            sacc1_reg <= mul_q30(sa_i, cc_i);
            cacb1_reg <= mul_q30(ca_i, cb_i);
            sb1_reg   <= sb_i;
            sc1_reg   <= sc_i;
            cc1_reg   <= cc_i;
            scl1_reg  <= scale_i;
            tr1_reg   <= trans_i;

            sasbcc2_reg <= mul_q30(sasb1_reg, cc1_reg);
            sasbsc2_reg <= mul_q30(sasb1_reg, sc1_reg);
            casbcc2_reg <= mul_q30(casb1_reg, cc1_reg);
            casbsc2_reg <= mul_q30(casb1_reg, sc1_reg);
            cbcc2_reg   <= cbcc1_reg;
            cbsc2_reg   <= cbsc1_reg;
            casc2_reg   <= casc1_reg;
            cacc2_reg   <= cacc1_reg;
            sacb2_reg   <= sacb1_reg;
            sasc2_reg   <= sasc1_reg;
            sacc2_reg   <= sacc1_reg;
            cacb2_reg   <= cacb1_reg;
            sb2_reg     <= sb1_reg;
            scl2_reg    <= scl1_reg;
            tr2_reg     <= tr1_reg;

            r3_reg[0] <= RW'(cbcc2_reg);
            r3_reg[1] <= -RW'(cbsc2_reg);
            r3_reg[2] <= RW'(sb2_reg);
            r3_reg[3] <= RW'(casc2_reg) + RW'(sasbcc2_reg);
            r3_reg[4] <= RW'(cacc2_reg) - RW'(sasbsc2_reg);
            r3_reg[5] <= -RW'(sacb2_reg);
            r3_reg[6] <= RW'(sasc2_reg) - RW'(casbcc2_reg);
            r3_reg[7] <= RW'(sacc2_reg) + RW'(casbsc2_reg);
            r3_reg[8] <= RW'(cacb2_reg);
            scl3_reg  <= scl2_reg;
            tr3_reg   <= tr2_reg;

            tr4_reg   <= tr3_reg;
        end
    end

    assign scl3[0] = scl3_reg.x;
    assign scl3[1] = scl3_reg.y;
    assign scl3[2] = scl3_reg.z;
    assign tr4[0]  = tr4_reg.x;
    assign tr4[1]  = tr4_reg.y;
    assign tr4[2]  = tr4_reg.z;

    for (genvar k = 0; k < 9; k++) begin : g_entry
        localparam int COL = k % 3;
        logic signed [PW-1:0] t;
        logic signed [VW-1:0] v;
        q16_t                 sat;

        always_comb begin
            t = p4_reg[k] + 65'sd536870912;
            v = VW'(t >>> 30);
            if (v > 35'sd2147483647) begin
                sat = 32'sh7FFFFFFF;
            end else if (v < -35'sd2147483648) begin
                sat = 32'sh80000000;
            end else begin
                sat = FW'(v);
            end
        end

        assign entry_sat[k] = sat;

        always_ff @(posedge aclk) begin
            if (en) begin
                p4_reg[k] <= PW'(r3_reg[k]) * PW'(scl3[COL]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    data_reg[(r*4+c)*FW +: FW] <= entry_sat[r*3+c];
                end
                data_reg[(r*4+3)*FW +: FW] <= tr4[r];
            end
        end
    end

    assign valid_o = v5_reg;
    assign data_o  = data_reg;

endmodule

FILE: hw/rtl/trs_checker.sv
// Port-level checker for the transform matrix pipeline, with its bind to the top level.
module trs_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic [trs_pkg::IN_W-1:0]  s_tdata,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [trs_pkg::OUT_W-1:0] m_tdata
);
    // A stalled result word holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // The input side only stalls behind a waiting result.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with no result waiting");

    // Nothing is offered straight after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

    // Free output means the pipeline takes a word every cycle.
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output register");

endmodule

bind trs_transform_matrix trs_checker u_trs_checker (.*);
